// ===== hw/rtl/cptlp_pkg.sv =====
// ----------------------------------------------------------------------------
// cptlp_pkg: shared types and constants for the cascaded lowpass filter
// Fixed field widths, the default geometry, sequencer states and the control
// word that the sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package cptlp_pkg;

  // Default geometry, handed to the top-level parameters
  localparam int DEF_SAMPLE_WIDTH  = 16;
  localparam int DEF_FRACTION_BITS = 16;
  localparam int DEF_MAX_STAGES    = 3;

  // Gain register: unsigned Q1.16, 1.0 is the largest useful value
  localparam int GAIN_W    = 17;
  localparam int GAIN_FRAC = 16;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

  // Order register and result width
  localparam int ORDER_W = 2;
  localparam int OUT_W   = 32;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORDER = 1'b1;

  // Input action codes
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } cptlp_state_t;

  // Datapath control word
  typedef struct packed {
    logic load;   // capture a new sample into the feed register
    logic clear;  // zero every stage and the feed register
    logic mul;    // register gain * (feed - stage)
    logic acc;    // add the rounded step into the stage and the feed
  } cptlp_ctrl_t;

endpackage

// ===== hw/rtl/cascaded_pt_lowpass_filter_top.sv =====
// ----------------------------------------------------------------------------
// cascaded_pt_lowpass_filter_top: cascaded first-order IIR lowpass filter
// Runs each sample through 1 to MAX_STAGES identical stages s += k*(x - s)
// with one shared multiplier and returns the last active stage in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: s_tdata carries the signed sample, s_tuser the action
//   (0 filters the sample, 1 clears every stage). Master stream: m_tdata
//   carries the filtered value of the last active stage, low 32 bits.
//   Config channel: cfg_index 0 writes the gain (Q1.16, 65536 = 1.0, larger
//   values act as 1.0), cfg_index 1 writes the order. Write only when idle.
// Sequence:
//   A filter request walks each active stage in turn: a multiply state on
//   the shared multiplier, then a round and accumulate state; a done state
//   then hands the result to the output register, from which m_tvalid is
//   registered. A clear request goes straight to the done state and
//   returns zero.
// Reset: stages clear to zero, gain to 1.0, order to 1, no result pending.
// Stall: a result waits in the output register while the next request is
//   worked; the sequencer holds its finished result until that register
//   drains, and s_tready stays low until then.
// ----------------------------------------------------------------------------
module cascaded_pt_lowpass_filter_top
  import cptlp_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = DEF_SAMPLE_WIDTH,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int MAX_STAGES    = DEF_MAX_STAGES
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,   // [SAMPLE_WIDTH-1:0] sample
  input  logic [0:0]                          s_tuser,   // [0] action
  // Output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [OUT_W-1:0]                    m_tdata,   // [31:0] filtered
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [CFG_INDEX_W-1:0]              cfg_index,
  input  logic [GAIN_W-1:0]                   cfg_data
);

  localparam int IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int VAL_W = SAMPLE_WIDTH + FRACTION_BITS;

  logic [GAIN_W-1:0]              gain;
  logic [ORDER_W-1:0]             order;
  cptlp_ctrl_t                    ctrl;
  logic [IDX_W-1:0]               idx;
  logic signed [VAL_W-1:0]        feed;
  logic signed [63:0]             feed_wide;
  logic                           out_load;
  logic                           out_free;

  // Configuration registers; clamp the gain to 1.0 on write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain  <= GAIN_ONE;
      order <= ORDER_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN: begin
          gain <= (cfg_data > GAIN_ONE) ? GAIN_ONE : cfg_data;
        end
        REG_ORDER: begin
          order <= cfg_data[ORDER_W-1:0];
        end
        default: begin
          gain <= gain;
        end
      endcase
    end
  end

  // Sequencer
  assign out_free = !m_tvalid || m_tready;

  cptlp_seq #(
    .MAX_STAGES (MAX_STAGES),
    .IDX_W      (IDX_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_action (s_tuser[0]),
    .order     (order),
    .out_free  (out_free),
    .in_ready  (s_tready),
    .out_load  (out_load),
    .ctrl      (ctrl),
    .idx       (idx)
  );

  // Stage registers and shared arithmetic
  cptlp_datapath #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .MAX_STAGES    (MAX_STAGES),
    .IDX_W         (IDX_W),
    .VAL_W         (VAL_W)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .idx    (idx),
    .sample (signed'(s_tdata[SAMPLE_WIDTH-1:0])),
    .gain   (gain),
    .feed   (feed)
  );

  // Output register: sign-extend or truncate the stage value to 32 bits
  assign feed_wide = 64'(feed);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= feed_wide[OUT_W-1:0];
    end
  end

  // Checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending result");

  a_filter_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser[0] == ACT_FILTER)) |=> !s_tready ##1 !s_tready)
    else $error("filter request accepted before stage walk ended");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser[0] == ACT_CLEAR)) |=> (feed == '0))
    else $error("clear request left a nonzero result");

endmodule

// ===== hw/rtl/cptlp_datapath.sv =====
// ----------------------------------------------------------------------------
// cptlp_datapath: stage registers and the shared multiply-round-add unit
// One multiplier serves every stage in turn: a multiply cycle registers
// gain * (feed - stage), an accumulate cycle rounds it and updates the stage and the feed.
// ----------------------------------------------------------------------------
module cptlp_datapath
  import cptlp_pkg::*;
#(
  parameter int SAMPLE_WIDTH  = DEF_SAMPLE_WIDTH,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int MAX_STAGES    = DEF_MAX_STAGES,
  parameter int IDX_W         = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1,
  parameter int VAL_W         = SAMPLE_WIDTH + FRACTION_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cptlp_ctrl_t                    ctrl,
  input  logic [IDX_W-1:0]               idx,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic [GAIN_W-1:0]              gain,
  output logic signed [VAL_W-1:0]        feed
);

  localparam int DIFF_W = VAL_W + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_FRAC - 1);

  logic signed [VAL_W-1:0]  stage_values [MAX_STAGES];
  logic signed [VAL_W-1:0]  cur;
  logic signed [DIFF_W-1:0] diff;
  logic signed [GAIN_W:0]   gain_s;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        rounded;
  logic [VAL_W-1:0]         step;
  logic signed [VAL_W-1:0]  updated;

  // Select the stage under work
  assign cur    = stage_values[idx];
  assign diff   = {feed[VAL_W-1], feed} - {cur[VAL_W-1], cur};
  assign gain_s = {1'b0, gain};

  // Round to nearest, ties upward, then drop the Q1.16 gain fraction
  assign rounded = prod + ROUND_HALF;
  assign step    = rounded[GAIN_FRAC +: VAL_W];
  assign updated = cur + step;

  // Register the product
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= diff * gain_s;
    end
  end

  // Feed register: new sample, or the stage just updated
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      feed <= '0;
    end else if (ctrl.load) begin
      feed <= {sample, {FRACTION_BITS{1'b0}}};
    end else if (ctrl.acc) begin
      feed <= updated;
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int i = 0; i < MAX_STAGES; i++) begin
        stage_values[i] <= '0;
      end
    end else if (ctrl.acc) begin
      stage_values[idx] <= updated;
    end
  end

endmodule

// ===== hw/rtl/cptlp_seq.sv =====
// ----------------------------------------------------------------------------
// cptlp_seq: sequencer for the cascaded lowpass filter
// Walks the active stages through a multiply and an accumulate state each,
// then waits for the output register to take the result.
// ----------------------------------------------------------------------------
module cptlp_seq
  import cptlp_pkg::*;
#(
  parameter int MAX_STAGES = DEF_MAX_STAGES,
  parameter int IDX_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_action,
  input  logic [ORDER_W-1:0] order,
  input  logic               out_free,
  output logic               in_ready,
  output logic               out_load,
  output cptlp_ctrl_t        ctrl,
  output logic [IDX_W-1:0]   idx
);

  cptlp_state_t     state, state_next;
  logic [IDX_W-1:0] idx_next;
  logic [IDX_W-1:0] last;

  // Last active stage, with order zero and oversize orders clamped
  always_comb begin
    if (order == '0) begin
      last = '0;
    end else if (32'(order) > MAX_STAGES) begin
      last = IDX_W'(MAX_STAGES - 1);
    end else begin
      last = IDX_W'(order - 1'b1);
    end
  end

  // Next state and stage index
  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (in_valid) begin
          state_next = (in_action == ACT_CLEAR) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (idx == last) begin
          state_next = ST_DONE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs per state
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    ctrl     = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.clear = (in_action == ACT_CLEAR);
          ctrl.load  = (in_action == ACT_FILTER);
        end
      end
      ST_MUL: begin
        ctrl.mul = 1'b1;
      end
      ST_ACC: begin
        ctrl.acc = 1'b1;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule
